// ===== hdl/slbb_pkg.sv =====
// Shared types and constants of the status LED blink and breathe generator.
package slbb_pkg;

   // Field widths
   localparam int TIME_W    = 32;
   localparam int MS_W      = 16;
   localparam int CHAN_W    = 8;
   localparam int COLOUR_W  = 3 * CHAN_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   // Serial divider geometry
   localparam int DIV_NUM_W  = 32;
   localparam int DIV_DEN_W  = 16;
   localparam int DIV_QUO_W  = 24;
   localparam int DIV_STEP_W = 6;

   // Effect modes; any other code behaves as steady
   localparam logic [1:0] MODE_BLINK   = 2'd1;
   localparam logic [1:0] MODE_BREATHE = 2'd2;

   // Timing and level constants
   localparam logic [MS_W-1:0]       DEFAULT_PHASE_MS = 16'd250;
   localparam logic [MS_W-1:0]       MIN_BREATHE_MS   = 16'd200;
   localparam logic [CHAN_W-1:0]     BREATHE_FLOOR    = 8'd12;
   localparam logic [CHAN_W-1:0]     LEVEL_MAX        = 8'd255;
   localparam logic [2*CHAN_W:0]     ROUND_BIAS       = 17'd127;
   localparam logic [DIV_STEP_W-1:0] MOD_STEPS        = 6'd32;
   localparam logic [DIV_STEP_W-1:0] RAMP_STEPS       = 6'd24;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUTPUT_ENABLE     = 3'd0,
      CSR_EFFECT_MODE       = 3'd1,
      CSR_BASE_COLOR        = 3'd2,
      CSR_BRIGHTNESS        = 3'd3,
      CSR_BLINK_ON_MS       = 3'd4,
      CSR_BLINK_OFF_MS      = 3'd5,
      CSR_BREATHE_PERIOD_MS = 3'd6
   } csr_index_type;

   // Command to the serial divider
   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
   } div_cmd_type;

   // Status back from the serial divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== hdl/slbb_req_if.sv =====
// Request channel: time stamp words with a restart flag.
interface slbb_req_if;
   logic                          valid;
   logic                          ready;
   logic [slbb_pkg::TIME_W-1:0]   now_ms;
   logic                          restart;

   modport source (output valid, output now_ms, output restart, input ready);
   modport sink   (input valid, input now_ms, input restart, output ready);
endinterface

// ===== hdl/slbb_rsp_if.sv =====
// Response channel: scaled RGB words with a write strobe.
interface slbb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [slbb_pkg::CHAN_W-1:0]   out_red;
   logic [slbb_pkg::CHAN_W-1:0]   out_green;
   logic [slbb_pkg::CHAN_W-1:0]   out_blue;
   logic                          write_strobe;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output write_strobe, input ready);
   modport sink   (input valid, input out_red, input out_green, input out_blue,
                   input write_strobe, output ready);
endinterface

// ===== hdl/slbb_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, dividend left-aligned.
module slbb_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  slbb_pkg::div_cmd_type               cmd,
   input  logic [slbb_pkg::DIV_NUM_W-1:0]      dividend,
   input  logic [slbb_pkg::DIV_DEN_W-1:0]      divisor,
   output slbb_pkg::div_stat_type              stat,
   output logic [slbb_pkg::DIV_QUO_W-1:0]      quotient,
   output logic [slbb_pkg::DIV_DEN_W-1:0]      remainder
);

   logic [slbb_pkg::DIV_NUM_W-1:0]  num_ff;
   logic [slbb_pkg::DIV_QUO_W-1:0]  quo_ff;
   logic [slbb_pkg::DIV_DEN_W-1:0]  rem_ff;
   logic [slbb_pkg::DIV_STEP_W-1:0] cnt_ff;
   logic                            busy_ff;
   logic                            done_ff;
   logic [slbb_pkg::DIV_DEN_W:0]    trial_in;
   logic [slbb_pkg::DIV_DEN_W:0]    diff_in;
   logic                            fits_in;

   // Bring down the next dividend bit and try the subtraction
   always_comb begin
      trial_in = {rem_ff, num_ff[slbb_pkg::DIV_NUM_W-1]};
      diff_in  = trial_in - {1'b0, divisor};
      fits_in  = (trial_in >= {1'b0, divisor});
   end

   // Advance one step a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == 1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift the datapath registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         num_ff <= dividend;
         quo_ff <= '0;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[slbb_pkg::DIV_NUM_W-2:0], 1'b0};
         quo_ff <= {quo_ff[slbb_pkg::DIV_QUO_W-2:0], fits_in};
         rem_ff <= fits_in ? diff_in[slbb_pkg::DIV_DEN_W-1:0]
                           : trial_in[slbb_pkg::DIV_DEN_W-1:0];
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/slbb_scaler.sv =====
// Channel scaler: one channel a cycle, (c * level + 127) / 255 by reciprocal.
module slbb_scaler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [slbb_pkg::COLOUR_W-1:0]      colour,
   input  logic [slbb_pkg::CHAN_W-1:0]        level,
   output logic                               done,
   output logic [slbb_pkg::CHAN_W-1:0]        red,
   output logic [slbb_pkg::CHAN_W-1:0]        green,
   output logic [slbb_pkg::CHAN_W-1:0]        blue
);

   logic [1:0]                      idx_ff;
   logic                            busy_ff;
   logic                            done_ff;
   logic [slbb_pkg::CHAN_W-1:0]     red_ff;
   logic [slbb_pkg::CHAN_W-1:0]     green_ff;
   logic [slbb_pkg::CHAN_W-1:0]     blue_ff;
   logic [slbb_pkg::CHAN_W-1:0]     chan_in;
   logic [2*slbb_pkg::CHAN_W:0]     biased_in;
   logic [2*slbb_pkg::CHAN_W:0]     recip_in;
   logic [slbb_pkg::CHAN_W-1:0]     scaled_in;

   // Pick the channel and divide by 255 as (x + x/256 + 1) / 256
   always_comb begin
      case (idx_ff)
         2'd0:    chan_in = colour[23:16];
         2'd1:    chan_in = colour[15:8];
         default: chan_in = colour[7:0];
      endcase
      biased_in = 17'(chan_in * level) + slbb_pkg::ROUND_BIAS;
      recip_in  = biased_in + 17'(biased_in[16:8]) + 17'd1;
      scaled_in = recip_in[15:8];
   end

   // Step through red, green, blue
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (busy_ff) begin
            idx_ff <= idx_ff + 1'b1;
            if (idx_ff == 2'd2) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Hold each result
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         case (idx_ff)
            2'd0:    red_ff   <= scaled_in;
            2'd1:    green_ff <= scaled_in;
            default: blue_ff  <= scaled_in;
         endcase
      end
   end

   assign done  = done_ff;
   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;

endmodule

// ===== hdl/status_led_blink_breathe_generator.sv =====
// Status LED blink and breathe generator: one RGB word per time stamp word.
// Each word passes from the accepting edge through update and scaling to a valid
// word in steady and blink modes, and through the 32-step modulo and 24-step ramp
// division as well in breathe mode. The next word is taken once the current one
// has reached the output register, which may wait.
// Reset (synchronous): configuration registers return to defaults, blink phase on, timers 0.
module status_led_blink_breathe_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   slbb_req_if.sink                             req,
   slbb_rsp_if.source                           rsp,
   input  logic                                 csr_wr_en,
   input  logic [slbb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [slbb_pkg::CSR_DAT_W-1:0]       csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MOD,
      ST_RAMP_MUL,
      ST_RAMP,
      ST_SCALE,
      ST_DONE
   } state_type;

   // Configuration registers
   logic                               enable_ff;
   logic [1:0]                         mode_ff;
   logic [slbb_pkg::COLOUR_W-1:0]      colour_ff;
   logic [slbb_pkg::CHAN_W-1:0]        bright_ff;
   logic [slbb_pkg::MS_W-1:0]          on_ms_ff;
   logic [slbb_pkg::MS_W-1:0]          off_ms_ff;
   logic [slbb_pkg::MS_W-1:0]          period_ff;

   // Effect state
   state_type                          state_ff;
   logic                               phase_on_ff;
   logic [slbb_pkg::TIME_W-1:0]        phase_start_ff;
   logic [slbb_pkg::TIME_W-1:0]        breathe_start_ff;
   logic [slbb_pkg::COLOUR_W-1:0]      last_colour_ff;
   logic                               last_valid_ff;

   // Per-word working registers
   logic [slbb_pkg::TIME_W-1:0]        now_ff;
   logic                               restart_ff;
   logic                               force_ff;
   logic [slbb_pkg::CHAN_W-1:0]        level_ff;
   logic [slbb_pkg::MS_W-1:0]          ramp_ff;
   slbb_pkg::div_cmd_type              div_cmd_ff;
   logic [slbb_pkg::DIV_NUM_W-1:0]     div_num_ff;
   logic [slbb_pkg::DIV_DEN_W-1:0]     div_den_ff;
   logic                               scale_start_ff;

   // Response register
   logic                               rsp_valid_ff;
   logic [slbb_pkg::CHAN_W-1:0]        red_ff;
   logic [slbb_pkg::CHAN_W-1:0]        green_ff;
   logic [slbb_pkg::CHAN_W-1:0]        blue_ff;
   logic                               strobe_ff;

   // Unit links
   slbb_pkg::div_stat_type             div_stat;
   logic [slbb_pkg::DIV_QUO_W-1:0]     div_quo;
   logic [slbb_pkg::DIV_DEN_W-1:0]     div_rem;
   logic                               scale_done;
   logic [slbb_pkg::CHAN_W-1:0]        scale_red;
   logic [slbb_pkg::CHAN_W-1:0]        scale_green;
   logic [slbb_pkg::CHAN_W-1:0]        scale_blue;

   // Combinational values
   logic                               is_blink_in;
   logic                               is_breathe_in;
   logic                               on_in;
   logic [slbb_pkg::TIME_W-1:0]        pstart_in;
   logic [slbb_pkg::TIME_W-1:0]        bstart_in;
   logic                               force_in;
   logic [slbb_pkg::MS_W-1:0]          len_in;
   logic [slbb_pkg::TIME_W-1:0]        elapsed_in;
   logic                               lit_in;
   logic [slbb_pkg::MS_W-1:0]          period_in;
   logic [slbb_pkg::MS_W-2:0]          half_in;
   logic [slbb_pkg::MS_W-1:0]          ramp_in;
   logic [slbb_pkg::CHAN_W-1:0]        span_in;
   logic [slbb_pkg::DIV_QUO_W-1:0]     prod_in;
   logic [slbb_pkg::DIV_QUO_W:0]       lvl_sum_in;
   logic [slbb_pkg::CHAN_W-1:0]        lvl_in;
   logic [slbb_pkg::COLOUR_W-1:0]      colour_in;
   logic                               write_in;
   logic                               rsp_free_in;

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         mode_ff   <= '0;
         colour_ff <= '0;
         bright_ff <= slbb_pkg::LEVEL_MAX;
         on_ms_ff  <= slbb_pkg::DEFAULT_PHASE_MS;
         off_ms_ff <= slbb_pkg::DEFAULT_PHASE_MS;
         period_ff <= slbb_pkg::MIN_BREATHE_MS;
      end else if (csr_wr_en) begin
         case (slbb_pkg::csr_index_type'(csr_index))
            slbb_pkg::CSR_OUTPUT_ENABLE:     enable_ff <= csr_wr_data[0];
            slbb_pkg::CSR_EFFECT_MODE:       mode_ff   <= csr_wr_data[1:0];
            slbb_pkg::CSR_BASE_COLOR:        colour_ff <= csr_wr_data[23:0];
            slbb_pkg::CSR_BRIGHTNESS:        bright_ff <= csr_wr_data[7:0];
            slbb_pkg::CSR_BLINK_ON_MS:       on_ms_ff  <= csr_wr_data[15:0];
            slbb_pkg::CSR_BLINK_OFF_MS:      off_ms_ff <= csr_wr_data[15:0];
            slbb_pkg::CSR_BREATHE_PERIOD_MS: period_ff <= csr_wr_data[15:0];
            default: ;
         endcase
      end
   end

   // Apply restart, then the steady and blink phase rules
   always_comb begin
      is_blink_in   = (mode_ff == slbb_pkg::MODE_BLINK);
      is_breathe_in = (mode_ff == slbb_pkg::MODE_BREATHE);
      on_in     = restart_ff | phase_on_ff;
      pstart_in = restart_ff ? now_ff : phase_start_ff;
      bstart_in = restart_ff ? now_ff : breathe_start_ff;
      force_in  = restart_ff;
      len_in    = on_in ? on_ms_ff : off_ms_ff;
      if (len_in == '0) begin
         len_in = slbb_pkg::DEFAULT_PHASE_MS;
      end
      elapsed_in = now_ff - pstart_in;
      if (!enable_ff || (!is_blink_in && !is_breathe_in)) begin
         if (!on_in) begin
            on_in     = 1'b1;
            pstart_in = now_ff;
            force_in  = 1'b1;
         end
      end else if (is_blink_in) begin
         if (elapsed_in >= 32'(len_in)) begin
            on_in     = !on_in;
            pstart_in = now_ff;
            force_in  = 1'b1;
         end
      end
      lit_in = enable_ff && (!is_blink_in || on_in);
   end

   // Breathe ramp terms
   always_comb begin
      period_in  = (period_ff < slbb_pkg::MIN_BREATHE_MS) ? slbb_pkg::MIN_BREATHE_MS
                                                          : period_ff;
      half_in    = period_in[slbb_pkg::MS_W-1:1];
      ramp_in    = (div_rem < {1'b0, half_in}) ? div_rem : (period_in - div_rem);
      span_in    = (bright_ff > slbb_pkg::BREATHE_FLOOR) ?
                   (bright_ff - slbb_pkg::BREATHE_FLOOR) : '0;
      prod_in    = 24'(span_in) * 24'(ramp_ff);
      lvl_sum_in = 25'(div_quo) + 25'(slbb_pkg::BREATHE_FLOOR);
      lvl_in     = (lvl_sum_in > 25'(slbb_pkg::LEVEL_MAX)) ? slbb_pkg::LEVEL_MAX
                                                           : lvl_sum_in[7:0];
   end

   // Decide the write
   always_comb begin
      colour_in   = {scale_red, scale_green, scale_blue};
      write_in    = force_ff || !last_valid_ff || (last_colour_ff != colour_in);
      rsp_free_in = !rsp_valid_ff || rsp.ready;
   end

   // Sequence one word through update, divisions in breathe mode, scaling and output
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         phase_on_ff      <= 1'b1;
         phase_start_ff   <= '0;
         breathe_start_ff <= '0;
         last_colour_ff   <= '0;
         last_valid_ff    <= 1'b0;
         div_cmd_ff       <= '0;
         scale_start_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // Pulse the divider and scaler starts on entry to their wait states
         div_cmd_ff.start <= ((state_ff == ST_UPDATE) && lit_in && is_breathe_in) ||
                             (state_ff == ST_RAMP_MUL);
         scale_start_ff   <= ((state_ff == ST_UPDATE) && !(lit_in && is_breathe_in)) ||
                             ((state_ff == ST_RAMP) && div_stat.done);
         // Load the response register, or drop the word once taken
         if ((state_ff == ST_DONE) && rsp_free_in) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  now_ff     <= req.now_ms;
                  restart_ff <= req.restart;
                  state_ff   <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               phase_on_ff      <= on_in;
               phase_start_ff   <= pstart_in;
               breathe_start_ff <= bstart_in;
               force_ff         <= force_in;
               if (lit_in && is_breathe_in) begin
                  div_num_ff       <= now_ff - bstart_in;
                  div_den_ff       <= period_in;
                  div_cmd_ff.steps <= slbb_pkg::MOD_STEPS;
                  state_ff         <= ST_MOD;
               end else begin
                  level_ff <= lit_in ? bright_ff : '0;
                  state_ff <= ST_SCALE;
               end
            end
            ST_MOD: begin
               if (div_stat.done) begin
                  ramp_ff  <= ramp_in;
                  state_ff <= ST_RAMP_MUL;
               end
            end
            ST_RAMP_MUL: begin
               div_num_ff       <= {prod_in, 8'h00};
               div_den_ff       <= {1'b0, half_in};
               div_cmd_ff.steps <= slbb_pkg::RAMP_STEPS;
               state_ff         <= ST_RAMP;
            end
            ST_RAMP: begin
               if (div_stat.done) begin
                  level_ff <= lvl_in;
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               if (scale_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_free_in) begin
                  red_ff    <= scale_red;
                  green_ff  <= scale_green;
                  blue_ff   <= scale_blue;
                  strobe_ff <= write_in;
                  if (write_in) begin
                     last_colour_ff <= colour_in;
                     last_valid_ff  <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   slbb_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd_ff),
      .dividend  (div_num_ff),
      .divisor   (div_den_ff),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   slbb_scaler u_scaler (
      .clock  (clock),
      .reset  (reset),
      .start  (scale_start_ff),
      .colour (colour_ff),
      .level  (level_ff),
      .done   (scale_done),
      .red    (scale_red),
      .green  (scale_green),
      .blue   (scale_blue)
   );

   // Drive the channels
   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_red      = red_ff;
   assign rsp.out_green    = green_ff;
   assign rsp.out_blue     = blue_ff;
   assign rsp.write_strobe = strobe_ff;

endmodule

// ===== hdl/slbb_checker.sv =====
// Port-level checks of the generator and their attachment to the top level.
module slbb_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [slbb_pkg::CHAN_W-1:0]  rsp_red,
   input  logic [slbb_pkg::CHAN_W-1:0]  rsp_green,
   input  logic [slbb_pkg::CHAN_W-1:0]  rsp_blue,
   input  logic                         rsp_strobe
);

   logic [1:0] pend_ff;
   logic [1:0] pend_in;
   logic       req_acc;
   logic       rsp_acc;

   // Count words taken but not yet delivered
   always_comb begin
      req_acc = req_valid && req_ready;
      rsp_acc = rsp_valid && rsp_ready;
      case ({req_acc, rsp_acc})
         2'b10:   pend_in = pend_ff + 2'd1;
         2'b01:   pend_in = pend_ff - 2'd1;
         default: pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A stalled response holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable({rsp_red, rsp_green, rsp_blue, rsp_strobe}))
      else $error("response word changed while stalled");

   // One word in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in work");

   // No response without a word taken
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response with no word outstanding");

   // Output register and working slot both full blocks requests
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd2 |-> !req_ready)
      else $error("request ready with two words outstanding");

endmodule

bind status_led_blink_breathe_generator slbb_checker u_slbb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_red    (rsp.out_red),
   .rsp_green  (rsp.out_green),
   .rsp_blue   (rsp.out_blue),
   .rsp_strobe (rsp.write_strobe)
);
